@@ design/tmcb_pkg.sv @@
package tmcb_pkg;

  typedef enum logic [2:0] {
    FMT_UNKNOWN = 3'd0,
    FMT_RGBA8   = 3'd1,
    FMT_BC1     = 3'd2,
    FMT_BC2     = 3'd3,
    FMT_BC3     = 3'd4,
    FMT_BC4     = 3'd5,
    FMT_BC5     = 3'd6,
    FMT_BC7     = 3'd7
  } fmt_code_t;

  // block byte count as a left shift of 4
  localparam logic [1:0] BSH_4B  = 2'd0;
  localparam logic [1:0] BSH_8B  = 2'd1;
  localparam logic [1:0] BSH_16B = 2'd2;

  localparam logic [30:0] BYTES_TOTAL_MAX = 31'h7fff_ffff;
  localparam logic [3:0]  CHAIN_MAX       = 4'd15;

  typedef struct packed {
    logic [2:0]  format_code;
    logic [14:0] base_width;
    logic [14:0] base_height;
    logic [3:0]  stored_mips;
    logic [3:0]  first_level;
  } in_t;

  typedef struct packed {
    logic        format_known;
    logic [30:0] level_bytes_total;
    logic [3:0]  full_chain_levels;
  } out_t;

  typedef struct packed {
    logic       known;
    logic       edge4;
    logic [1:0] bsh;
    logic [4:0] stored;
    logic [3:0] first;
    logic [3:0] chain;
  } lvl_ctl_t;

  // levels from a size down to 1x1: one plus the top set bit of w|h
  function automatic logic [3:0] chain_levels(input logic [15:0] v);
    logic [4:0] lv;
    lv = 5'd1;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) lv = 5'(i + 1);
    end
    chain_levels = (lv > 5'(CHAIN_MAX)) ? CHAIN_MAX : lv[3:0];
  endfunction

endpackage

@@ design/texture_mip_chain_bytes_unit.sv @@
// Throughput: one item per cycle while the output is not stalled; one pipeline stage
// per mip level, each with one block-count multiplier, plus a decode stage and an
// output stage.
// A held output stalls the whole pipeline; in_ready = out_ready | !out_valid.
// Reset: synchronous, active low; clears all stage valid bits, no data reset.
module texture_mip_chain_bytes_unit #(
  parameter int MAX_LEVELS = 15,
  parameter int MAX_DIM    = 16384
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  tmcb_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output tmcb_pkg::out_t  out_data
);

  localparam int L  = MAX_LEVELS;
  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int QW = 2 * DW;

  logic               en;
  logic [L:0]         st_vld;
  tmcb_pkg::lvl_ctl_t st_ctl   [0:L];
  logic [DW-1:0]      st_w     [0:L];
  logic [DW-1:0]      st_h     [0:L];
  logic [QW-1:0]      st_prod  [0:L];
  logic [30:0]        st_total [0:L];

  assign en       = out_ready || !out_valid;
  assign in_ready = en;

  tmcb_decode #(
    .MAX_LEVELS(MAX_LEVELS),
    .MAX_DIM   (MAX_DIM),
    .DW        (DW)
  ) u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_valid),
    .in_data(in_data),
    .vld_r  (st_vld[0]),
    .ctl_r  (st_ctl[0]),
    .w_r    (st_w[0]),
    .h_r    (st_h[0])
  );

  assign st_prod[0]  = '0;
  assign st_total[0] = '0;

  for (genvar k = 0; k < L; k++) begin : g_level
    tmcb_level #(
      .LEVEL(k),
      .DW   (DW)
    ) u_level (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (st_vld[k]),
      .in_ctl  (st_ctl[k]),
      .in_w    (st_w[k]),
      .in_h    (st_h[k]),
      .in_prod (st_prod[k]),
      .in_total(st_total[k]),
      .vld_r   (st_vld[k+1]),
      .ctl_r   (st_ctl[k+1]),
      .w_r     (st_w[k+1]),
      .h_r     (st_h[k+1]),
      .prod_r  (st_prod[k+1]),
      .total_r (st_total[k+1])
    );
  end

  tmcb_final #(
    .DW(DW)
  ) u_final (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (st_vld[L]),
    .in_ctl  (st_ctl[L]),
    .in_prod (st_prod[L]),
    .in_total(st_total[L]),
    .vld_r   (out_valid),
    .out_r   (out_data)
  );

  // last-level dims are not consumed further
  logic unused_dims;
  assign unused_dims = ^{st_w[L], st_h[L]};

endmodule

@@ design/tmcb_decode.sv @@
module tmcb_decode #(
  parameter int MAX_LEVELS = 15,
  parameter int MAX_DIM    = 16384,
  parameter int DW         = 15
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  tmcb_pkg::in_t       in_data,
  output logic                vld_r,
  output tmcb_pkg::lvl_ctl_t  ctl_r,
  output logic [DW-1:0]       w_r,
  output logic [DW-1:0]       h_r
);

  tmcb_pkg::lvl_ctl_t ctl_nxt;
  logic [DW-1:0]      w_nxt;
  logic [DW-1:0]      h_nxt;

  always_comb begin
    w_nxt = (32'(in_data.base_width) > MAX_DIM) ? DW'(MAX_DIM) : DW'(in_data.base_width);
    h_nxt = (32'(in_data.base_height) > MAX_DIM) ? DW'(MAX_DIM) : DW'(in_data.base_height);

    ctl_nxt.known  = 1'b1;
    ctl_nxt.edge4  = 1'b1;
    ctl_nxt.bsh    = tmcb_pkg::BSH_16B;
    unique case (tmcb_pkg::fmt_code_t'(in_data.format_code))
      tmcb_pkg::FMT_UNKNOWN: begin
        ctl_nxt.known = 1'b0;
        ctl_nxt.edge4 = 1'b0;
        ctl_nxt.bsh   = tmcb_pkg::BSH_4B;
      end
      tmcb_pkg::FMT_RGBA8: begin
        ctl_nxt.edge4 = 1'b0;
        ctl_nxt.bsh   = tmcb_pkg::BSH_4B;
      end
      tmcb_pkg::FMT_BC1, tmcb_pkg::FMT_BC4: begin
        ctl_nxt.bsh = tmcb_pkg::BSH_8B;
      end
      tmcb_pkg::FMT_BC2, tmcb_pkg::FMT_BC3, tmcb_pkg::FMT_BC5, tmcb_pkg::FMT_BC7: begin
        ctl_nxt.bsh = tmcb_pkg::BSH_16B;
      end
      default: begin
        ctl_nxt.known = 1'b0;
      end
    endcase

    ctl_nxt.stored = (5'(in_data.stored_mips) > 5'(MAX_LEVELS)) ? 5'(MAX_LEVELS)
                                                                 : 5'(in_data.stored_mips);
    ctl_nxt.first  = in_data.first_level;
    ctl_nxt.chain  = tmcb_pkg::chain_levels(16'(w_nxt | h_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r <= ctl_nxt;
      w_r   <= w_nxt;
      h_r   <= h_nxt;
    end
  end

endmodule

@@ design/tmcb_level.sv @@
module tmcb_level #(
  parameter int LEVEL = 0,
  parameter int DW    = 15
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  tmcb_pkg::lvl_ctl_t  in_ctl,
  input  logic [DW-1:0]       in_w,
  input  logic [DW-1:0]       in_h,
  input  logic [2*DW-1:0]     in_prod,
  input  logic [30:0]         in_total,
  output logic                vld_r,
  output tmcb_pkg::lvl_ctl_t  ctl_r,
  output logic [DW-1:0]       w_r,
  output logic [DW-1:0]       h_r,
  output logic [2*DW-1:0]     prod_r,
  output logic [30:0]         total_r
);

  localparam int         QW  = 2 * DW;
  localparam int         BW  = QW + 4;
  localparam int         SW  = ((BW > 31) ? BW : 31) + 1;
  localparam logic [4:0] LVL = 5'(LEVEL);

  logic [DW+1:0] wp3;
  logic [DW+1:0] hp3;
  logic [DW-1:0] bx;
  logic [DW-1:0] by;
  logic [DW-1:0] wh;
  logic [DW-1:0] hh;
  logic          counted;
  logic [QW-1:0] prod_nxt;
  logic [DW-1:0] w_nxt;
  logic [DW-1:0] h_nxt;
  logic [BW-1:0] lvl_bytes;
  logic [SW-1:0] sum;
  logic [30:0]   total_nxt;

  always_comb begin
    wp3 = (DW+2)'(in_w) + (DW+2)'(3);
    hp3 = (DW+2)'(in_h) + (DW+2)'(3);
    bx  = in_ctl.edge4 ? wp3[DW+1:2] : in_w;
    by  = in_ctl.edge4 ? hp3[DW+1:2] : in_h;
    counted  = in_ctl.known && (LVL >= 5'(in_ctl.first)) && (LVL < in_ctl.stored);
    prod_nxt = counted ? (QW'(bx) * QW'(by)) : '0;

    wh    = in_w >> 1;
    hh    = in_h >> 1;
    w_nxt = (wh == '0) ? DW'(1) : wh;
    h_nxt = (hh == '0) ? DW'(1) : hh;

    // previous level's block count enters the total here
    lvl_bytes = BW'(in_prod) << (3'(in_ctl.bsh) + 3'd2);
    sum       = SW'(lvl_bytes) + SW'(in_total);
    total_nxt = (sum > SW'(tmcb_pkg::BYTES_TOTAL_MAX)) ? tmcb_pkg::BYTES_TOTAL_MAX
                                                       : sum[30:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r   <= in_ctl;
      w_r     <= w_nxt;
      h_r     <= h_nxt;
      prod_r  <= prod_nxt;
      total_r <= total_nxt;
    end
  end

endmodule

@@ design/tmcb_final.sv @@
module tmcb_final #(
  parameter int DW = 15
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  tmcb_pkg::lvl_ctl_t  in_ctl,
  input  logic [2*DW-1:0]     in_prod,
  input  logic [30:0]         in_total,
  output logic                vld_r,
  output tmcb_pkg::out_t      out_r
);

  localparam int QW = 2 * DW;
  localparam int BW = QW + 4;
  localparam int SW = ((BW > 31) ? BW : 31) + 1;

  logic [BW-1:0]  lvl_bytes;
  logic [SW-1:0]  sum;
  tmcb_pkg::out_t out_nxt;

  always_comb begin
    lvl_bytes                 = BW'(in_prod) << (3'(in_ctl.bsh) + 3'd2);
    sum                       = SW'(lvl_bytes) + SW'(in_total);
    out_nxt.format_known      = in_ctl.known;
    out_nxt.level_bytes_total = (sum > SW'(tmcb_pkg::BYTES_TOTAL_MAX))
                                ? tmcb_pkg::BYTES_TOTAL_MAX : sum[30:0];
    out_nxt.full_chain_levels = in_ctl.chain;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

endmodule

@@ design/tmcb_checker.sv @@
module tmcb_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input tmcb_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input tmcb_pkg::out_t out_data
);

  logic unused_in;
  assign unused_in = in_valid ^ (^in_data);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output item changed while stalled");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.format_known |-> out_data.level_bytes_total == 31'd0)
    else $error("unknown format with nonzero bytes");

  a_chain_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.full_chain_levels != 4'd0)
    else $error("chain length zero");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind texture_mip_chain_bytes_unit tmcb_checker u_tmcb_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
